@@ design/bsp_pkg.sv @@
// shared types, codes and control tables of the bell swing phase controller
// no dependencies; used by every module under design/
package bsp_pkg;

    // event kinds carried in the op field
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_ZC   = 2'd1;
    localparam logic [1:0] OP_ENC  = 2'd2;

    // step actions
    localparam logic [1:0] ACT_STOP = 2'd0;
    localparam logic [1:0] ACT_FWD  = 2'd1;
    localparam logic [1:0] ACT_REV  = 2'd2;

    // threshold selectors
    localparam logic [2:0] SEL_ZERO      = 3'd0;
    localparam logic [2:0] SEL_SMALL     = 3'd1;
    localparam logic [2:0] SEL_NEG_SMALL = 3'd2;
    localparam logic [2:0] SEL_MID       = 3'd3;
    localparam logic [2:0] SEL_NEG_MID   = 3'd4;
    localparam logic [2:0] SEL_LARGE     = 3'd5;

    localparam logic [3:0] STEP_LAST_STARTER = 4'd8;
    localparam logic [3:0] STEP_RING_FIRST   = 4'd9;
    localparam logic [3:0] STEP_LAST         = 4'd12;

    // configuration register indexes
    localparam logic [2:0] CFG_STARTER_RELOAD = 3'd0;
    localparam logic [2:0] CFG_RING_RELOAD    = 3'd1;
    localparam logic [2:0] CFG_SWING_SMALL    = 3'd2;
    localparam logic [2:0] CFG_SWING_MID      = 3'd3;
    localparam logic [2:0] CFG_SWING_LARGE    = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    typedef struct packed {
        logic [1:0] act;
        logic       le;     // hold while pos <= threshold, else pos >= threshold
        logic [2:0] sel;
    } seq_entry_t;

    function automatic seq_entry_t seq_lookup(input logic [3:0] step);
        seq_entry_t e;
        unique case (step)
            4'd0:    e = '{ACT_FWD,  1'b1, SEL_SMALL};
            4'd1:    e = '{ACT_STOP, 1'b0, SEL_ZERO};
            4'd2:    e = '{ACT_REV,  1'b0, SEL_NEG_SMALL};
            4'd3:    e = '{ACT_STOP, 1'b1, SEL_ZERO};
            4'd4:    e = '{ACT_FWD,  1'b1, SEL_MID};
            4'd5:    e = '{ACT_STOP, 1'b0, SEL_ZERO};
            4'd6:    e = '{ACT_REV,  1'b0, SEL_NEG_MID};
            4'd7:    e = '{ACT_STOP, 1'b1, SEL_ZERO};
            4'd8:    e = '{ACT_FWD,  1'b1, SEL_LARGE};
            4'd10:   e = '{ACT_REV,  1'b0, SEL_NEG_MID};
            4'd11:   e = '{ACT_STOP, 1'b1, SEL_NEG_SMALL};
            4'd12:   e = '{ACT_FWD,  1'b1, SEL_MID};
            default: e = '{ACT_STOP, 1'b0, SEL_SMALL};   // step 9 and unused codes
        endcase
        return e;
    endfunction

    // micro-program addresses
    localparam logic [1:0] UPC_IDLE = 2'd0;
    localparam logic [1:0] UPC_EVAL = 2'd1;
    localparam logic [1:0] UPC_EMIT = 2'd2;
    localparam logic [1:0] UPC_SPARE = 2'd3;

    // jump conditions
    localparam logic [1:0] COND_IN_VALID = 2'd0;
    localparam logic [1:0] COND_HOLD     = 2'd1;
    localparam logic [1:0] COND_SLOT     = 2'd2;
    localparam logic [1:0] COND_ALWAYS   = 2'd3;

    typedef struct packed {
        logic accept;
        logic evt;
        logic eval;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        ctrl_t      ctrl;
        logic [1:0] cond;
        logic [1:0] target;
    } uword_t;

    function automatic uword_t ucode_rom(input logic [1:0] upc);
        uword_t w;
        unique case (upc)
            UPC_IDLE: w = '{'{1'b1, 1'b1, 1'b0, 1'b0}, COND_IN_VALID, UPC_EVAL};
            UPC_EVAL: w = '{'{1'b0, 1'b0, 1'b1, 1'b0}, COND_HOLD,     UPC_EMIT};
            UPC_EMIT: w = '{'{1'b0, 1'b0, 1'b0, 1'b1}, COND_SLOT,     UPC_IDLE};
            default:  w = '{'{1'b0, 1'b0, 1'b0, 1'b0}, COND_ALWAYS,   UPC_IDLE};
        endcase
        return w;
    endfunction

    typedef struct packed {
        logic        hold;
        logic        relay;
        logic        gate_fwd;
        logic        gate_rev;
        logic        stopped;
        logic [15:0] position;
        logic [3:0]  step;
        logic        starter_done;
    } status_t;

endpackage

@@ design/bell_swing_phase_controller_unit.sv @@
// sequence: the idle state takes the event from the input beat, the evaluate state tries
// swing steps until one holds, and the emit state loads the output register once it is free
// throughput: one item at a time, set by the micro-program walking the step table
// the output register holds a finished result while the next beat is taken
// reset: aresetn synchronous active low; restores default registers and step 0
module bell_swing_phase_controller_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [1:0] op, [2] dir_level
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] relay_on, [1] triac_fwd, [2] triac_rev, [18:3] position, [22:19] seq_step,
    // [23] starter_done
    output logic [23:0]                         m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [bsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bsp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    bsp_pkg::ctrl_t   ctrl;
    bsp_pkg::status_t status;
    logic             slot_free;
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;

    assign slot_free = ~m_tvalid_reg | m_tready;

    bsp_useq u_useq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .hold      (status.hold),
        .slot_free (slot_free),
        .ctrl      (ctrl)
    );

    bsp_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .op        (s_tdata[1:0]),
        .dir_level (s_tdata[2]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .status    (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            m_tdata_reg <= {status.starter_done, status.step, status.position,
                            status.gate_rev, status.gate_fwd, status.relay};
        end
    end

    assign s_tready = ctrl.accept;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // both triacs must never be gated together
    a_gates_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(status.gate_fwd && status.gate_rev))
        else $error("both triac gates high");

    // a stopped motor has its relay released
    a_stop_relay: assert property (@(posedge aclk) disable iff (!aresetn)
        status.stopped |-> !status.relay)
        else $error("relay on while stopped");

    // the step counter stays inside the table
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        status.step <= bsp_pkg::STEP_LAST)
        else $error("sequence step out of range");

    // a result is only loaded when the output register is free
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten");

    // the ring loop never returns to the starter steps
    a_ring_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(status.starter_done) |-> status.starter_done && status.step >= 4'd9)
        else $error("left ring loop");
`endif

endmodule

@@ design/bsp_useq.sv @@
// micro-program counter and control rom of the bell swing phase controller
// depends on bsp_pkg
module bsp_useq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                hold,
    input  logic                slot_free,
    output bsp_pkg::ctrl_t      ctrl
);

    logic [1:0]       upc_reg;
    logic [1:0]       upc_next;
    bsp_pkg::uword_t  uw;
    logic             take;

    always_comb begin
        uw = bsp_pkg::ucode_rom(upc_reg);
        unique case (uw.cond)
            bsp_pkg::COND_IN_VALID: take = in_valid;
            bsp_pkg::COND_HOLD:     take = hold;
            bsp_pkg::COND_SLOT:     take = slot_free;
            default:                take = 1'b1;
        endcase
        upc_next = take ? uw.target : upc_reg;
        ctrl.accept = uw.ctrl.accept;
        ctrl.evt    = uw.ctrl.evt & in_valid;
        ctrl.eval   = uw.ctrl.eval;
        ctrl.emit   = uw.ctrl.emit & slot_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= bsp_pkg::UPC_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

@@ design/bsp_datapath.sv @@
// configuration registers, timer, position counter and swing step state
// depends on bsp_pkg; driven by the control word from bsp_useq
module bsp_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bsp_pkg::ctrl_t                       ctrl,
    input  logic [1:0]                           op,
    input  logic                                 dir_level,
    input  logic                                 cfg_wr_en,
    input  logic [bsp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bsp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output bsp_pkg::status_t                     status
);

    logic [7:0]         starter_reload_reg;
    logic [7:0]         ring_reload_reg;
    logic [14:0]        swing_small_reg;
    logic [14:0]        swing_mid_reg;
    logic [14:0]        swing_large_reg;

    logic signed [15:0] pos_reg, pos_next;
    logic [3:0]         step_reg, step_next;
    logic               dir_fwd_reg, dir_fwd_next;
    logic               stopped_reg, stopped_next;
    logic               in_starter_reg, in_starter_next;
    logic [7:0]         timer_reg, timer_next;
    logic               armed_reg, armed_next;
    logic               gate_fwd_reg, gate_fwd_next;
    logic               gate_rev_reg, gate_rev_next;
    logic               relay_reg, relay_next;

    bsp_pkg::seq_entry_t entry;
    logic signed [15:0]  thr;
    logic                hold;
    logic [1:0]          act;

    // threshold compare for the current step
    always_comb begin
        entry = bsp_pkg::seq_lookup(step_reg);
        unique case (entry.sel)
            bsp_pkg::SEL_SMALL:     thr = $signed({1'b0, swing_small_reg});
            bsp_pkg::SEL_NEG_SMALL: thr = -$signed({1'b0, swing_small_reg});
            bsp_pkg::SEL_MID:       thr = $signed({1'b0, swing_mid_reg});
            bsp_pkg::SEL_NEG_MID:   thr = -$signed({1'b0, swing_mid_reg});
            bsp_pkg::SEL_LARGE:     thr = $signed({1'b0, swing_large_reg});
            default:                thr = 16'sd0;
        endcase
        hold = entry.le ? (pos_reg <= thr) : (pos_reg >= thr);
    end

    always_comb begin
        pos_next        = pos_reg;
        step_next       = step_reg;
        dir_fwd_next    = dir_fwd_reg;
        stopped_next    = stopped_reg;
        in_starter_next = in_starter_reg;
        timer_next      = timer_reg;
        armed_next      = armed_reg;
        gate_fwd_next   = gate_fwd_reg;
        gate_rev_next   = gate_rev_reg;
        relay_next      = relay_reg;
        act             = bsp_pkg::ACT_STOP;

        if (ctrl.evt) begin
            unique case (op)
                bsp_pkg::OP_TICK: begin
                    timer_next = timer_reg + 8'd1;
                    if (timer_reg == 8'hFF && armed_reg) begin
                        if (!stopped_reg) begin
                            if (dir_fwd_reg) gate_fwd_next = 1'b1;
                            else             gate_rev_next = 1'b1;
                        end
                        armed_next = 1'b0;
                    end
                end
                bsp_pkg::OP_ZC: begin
                    gate_fwd_next = 1'b0;
                    gate_rev_next = 1'b0;
                    timer_next    = in_starter_reg ? starter_reload_reg : ring_reload_reg;
                    armed_next    = 1'b1;
                end
                bsp_pkg::OP_ENC: begin
                    if (dir_level) begin
                        if (pos_reg != 16'sh7FFF) pos_next = pos_reg + 16'sd1;
                    end else begin
                        if (pos_reg != -16'sh8000) pos_next = pos_reg - 16'sd1;
                    end
                end
                default: ;
            endcase
        end else if (ctrl.eval) begin
            // a failed step stops the motor and moves on
            if (hold) begin
                act = entry.act;
            end else begin
                act = bsp_pkg::ACT_STOP;
                if (step_reg == bsp_pkg::STEP_LAST_STARTER) in_starter_next = 1'b0;
                step_next = (step_reg == bsp_pkg::STEP_LAST) ? bsp_pkg::STEP_RING_FIRST
                                                             : step_reg + 4'd1;
            end
            unique case (act)
                bsp_pkg::ACT_FWD: begin
                    relay_next    = 1'b1;
                    gate_rev_next = 1'b0;
                    dir_fwd_next  = 1'b1;
                    stopped_next  = 1'b0;
                end
                bsp_pkg::ACT_REV: begin
                    relay_next    = 1'b1;
                    gate_fwd_next = 1'b0;
                    dir_fwd_next  = 1'b0;
                    stopped_next  = 1'b0;
                end
                default: begin
                    relay_next    = 1'b0;
                    gate_fwd_next = 1'b0;
                    gate_rev_next = 1'b0;
                    stopped_next  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            starter_reload_reg <= 8'd235;
            ring_reload_reg    <= 8'd137;
            swing_small_reg    <= 15'd400;
            swing_mid_reg      <= 15'd800;
            swing_large_reg    <= 15'd1200;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bsp_pkg::CFG_STARTER_RELOAD: starter_reload_reg <= cfg_wdata[7:0];
                bsp_pkg::CFG_RING_RELOAD:    ring_reload_reg    <= cfg_wdata[7:0];
                bsp_pkg::CFG_SWING_SMALL:    swing_small_reg    <= cfg_wdata;
                bsp_pkg::CFG_SWING_MID:      swing_mid_reg      <= cfg_wdata;
                bsp_pkg::CFG_SWING_LARGE:    swing_large_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= 16'sd0;
            step_reg       <= 4'd0;
            dir_fwd_reg    <= 1'b1;
            stopped_reg    <= 1'b0;
            in_starter_reg <= 1'b1;
            timer_reg      <= 8'd0;
            armed_reg      <= 1'b1;
            gate_fwd_reg   <= 1'b0;
            gate_rev_reg   <= 1'b0;
            relay_reg      <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            step_reg       <= step_next;
            dir_fwd_reg    <= dir_fwd_next;
            stopped_reg    <= stopped_next;
            in_starter_reg <= in_starter_next;
            timer_reg      <= timer_next;
            armed_reg      <= armed_next;
            gate_fwd_reg   <= gate_fwd_next;
            gate_rev_reg   <= gate_rev_next;
            relay_reg      <= relay_next;
        end
    end

    always_comb begin
        status.hold         = hold;
        status.relay        = relay_reg;
        status.gate_fwd     = gate_fwd_reg;
        status.gate_rev     = gate_rev_reg;
        status.stopped      = stopped_reg;
        status.position     = pos_reg;
        status.step         = step_reg;
        status.starter_done = ~in_starter_reg;
    end

endmodule
